// ===== rtl/scrn_pkg.sv =====
// ----------------------------------------------------------------------------
// scrn_pkg
// Shared types and constants for the sparse column reweight/normalize block.
// ----------------------------------------------------------------------------
package scrn_pkg;

  localparam int ROWS        = 1024;
  localparam int MAX_ENTRIES = 32;

  localparam int ROW_W  = 10;
  localparam int VAL_W  = 32;
  localparam int WGT_W  = 31;                    // positive unsigned Q15.16 weight, saturated
  localparam int OUT_W  = 17;                    // unsigned Q1.16, 65536 = 1.0
  localparam int FRAC_W = 16;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SUM_W  = WGT_W + CNT_W;
  localparam int BIAS_AW = $clog2(ROWS);

  localparam int IN_DATA_W  = 48;                // row + value, padded to bytes
  localparam int OUT_DATA_W = 32;                // row + weight, padded to bytes

  typedef enum logic {
    CMD_BIAS  = 1'b0,
    CMD_ENTRY = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WGT,
    ST_READ,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [WGT_W-1:0] num;
    logic [SUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [OUT_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/scrn_weight_calc.sv =====
// ----------------------------------------------------------------------------
// scrn_weight_calc
// Registered Q16.16 product value*(1+bias), clamped to a positive weight.
// ----------------------------------------------------------------------------
module scrn_weight_calc import scrn_pkg::*; (
  input  logic                    clk,
  input  logic signed [VAL_W-1:0] value,
  input  logic signed [VAL_W-1:0] bias,
  output logic [WGT_W-1:0]        weight
);

  logic signed [VAL_W:0]     factor;
  logic signed [2*VAL_W:0]   prod;

  assign factor = (VAL_W+1)'(signed'(bias)) + (VAL_W+1)'(signed'(33'sd65536));

  always_ff @(posedge clk) begin
    prod <= (2*VAL_W+1)'(value) * (2*VAL_W+1)'(factor);
  end

  // non-positive products give zero; large ones clamp to the Q15.16 weight maximum
  always_comb begin
    if (prod[2*VAL_W] || (prod == '0)) begin
      weight = '0;
    end else if (|prod[2*VAL_W-1:FRAC_W+WGT_W]) begin
      weight = '1;
    end else begin
      weight = prod[FRAC_W+WGT_W-1:FRAC_W];
    end
  end

endmodule

// ===== rtl/scrn_divider.sv =====
// ----------------------------------------------------------------------------
// scrn_divider
// Restoring divider, one quotient bit per cycle: floor((num << 16) / den).
// ----------------------------------------------------------------------------
module scrn_divider import scrn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int BITS_W = $clog2(OUT_W);

  logic              busy;
  logic [BITS_W-1:0] bit_cnt;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  den;
  logic [OUT_W-1:0]  quot;
  logic              num_lsb;
  logic              done;
  logic [SUM_W:0]    trial;
  logic              fits;

  // the dividend bit below the preloaded part is num[0]; the rest are zero
  assign trial = {rem, (bit_cnt == BITS_W'(OUT_W - 1)) ? num_lsb : 1'b0};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (bit_cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= SUM_W'(req.num >> 1);
      num_lsb <= req.num[0];
      den     <= req.den;
      bit_cnt <= BITS_W'(OUT_W - 1);
      quot    <= '0;
    end else if (busy) begin
      rem     <= fits ? SUM_W'(trial - {1'b0, den}) : trial[SUM_W-1:0];
      quot    <= {quot[OUT_W-2:0], fits};
      bit_cnt <= bit_cnt - BITS_W'(1);
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// ===== rtl/sparse_column_reweight_normalize.sv =====
// ----------------------------------------------------------------------------
// sparse_column_reweight_normalize
// Per-row bias reweighting of sparse column entries with column normalization.
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  s_axis    in         tuser: command; tdata: row, value; tlast: last
//  m_axis    out        tdata: out_row, weight; tlast: out_last
//
//  A bias load is written on acceptance; a matrix entry passes the bias read,
//  multiply and accumulate steps. On an entry with tlast, each buffered result
//  is divided one bit per cycle (skipped on a zero sum), then waits for the sink.
//  Synchronous active-high reset clears the sequencer, entry count and sum;
//  the bias table holds garbage until loaded. s_axis_tready is low while an
//  entry or an emit pass is in progress.
// ----------------------------------------------------------------------------
module sparse_column_reweight_normalize import scrn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [9:0] row, [41:10] value, rest zero
  input  logic                  s_axis_tuser,   // [0] command
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [9:0] out_row, [26:10] weight, rest zero
  output logic                  m_axis_tlast
);

  state_t state, state_next;

  logic                    in_acc;
  logic [ROW_W-1:0]        in_row;
  logic signed [VAL_W-1:0] in_value;

  logic signed [VAL_W-1:0] bias_mem [ROWS];
  logic signed [VAL_W-1:0] bias_rd;
  logic [ROW_W-1:0]        col_row_mem [MAX_ENTRIES];
  logic [WGT_W-1:0]        col_wgt_mem [MAX_ENTRIES];
  logic [ROW_W-1:0]        col_row_rd;
  logic [WGT_W-1:0]        col_wgt_rd;

  logic signed [VAL_W-1:0] value;
  logic [ROW_W-1:0]        row;
  logic                    last;
  logic [WGT_W-1:0]        weight;

  logic [CNT_W-1:0]        count;
  logic [SUM_W-1:0]        sum;
  logic [CNT_W-1:0]        idx;
  logic                    room;
  logic                    emit_last;

  logic [ROW_W-1:0]        out_row;
  logic [OUT_W-1:0]        out_wgt;
  logic                    out_last;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_row   = s_axis_tdata[ROW_W-1:0];
  assign in_value = s_axis_tdata[ROW_W+VAL_W-1:ROW_W];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign room     = (count < CNT_W'(MAX_ENTRIES));
  assign emit_last = (idx == count - CNT_W'(1));

  scrn_weight_calc u_weight (
    .clk    (clk),
    .value  (value),
    .bias   (bias_rd),
    .weight (weight)
  );

  assign div_req.start = (state == ST_START) && (sum != '0);
  assign div_req.num   = col_wgt_rd;
  assign div_req.den   = sum;

  scrn_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && (cmd_t'(s_axis_tuser) == CMD_ENTRY)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:   state_next = ST_WGT;
      ST_WGT:   state_next = last ? ST_READ : ST_IDLE;
      ST_READ:  state_next = ST_START;
      ST_START: state_next = (sum == '0) ? ST_OUT : ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          state_next = out_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // bias table: write on load items, registered read for every accepted row
  always_ff @(posedge clk) begin
    if (in_acc && (cmd_t'(s_axis_tuser) == CMD_BIAS)) begin
      bias_mem[in_row[BIAS_AW-1:0]] <= in_value;
    end
    bias_rd <= bias_mem[in_row[BIAS_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      value <= in_value;
      row   <= in_row;
      last  <= s_axis_tlast;
    end
  end

  // column buffer; entries past the buffer depth are dropped
  always_ff @(posedge clk) begin
    if ((state == ST_WGT) && room) begin
      col_row_mem[count[IDX_W-1:0]] <= row;
      col_wgt_mem[count[IDX_W-1:0]] <= weight;
    end
    col_row_rd <= col_row_mem[idx[IDX_W-1:0]];
    col_wgt_rd <= col_wgt_mem[idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
      idx   <= '0;
    end else begin
      if ((state == ST_WGT) && room) begin
        count <= count + CNT_W'(1);
        sum   <= sum + SUM_W'(weight);
      end
      if (state == ST_WGT) begin
        idx <= '0;
      end else if ((state == ST_OUT) && m_axis_tready) begin
        if (out_last) begin
          count <= '0;
          sum   <= '0;
        end else begin
          idx <= idx + CNT_W'(1);
        end
      end
    end
  end

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if ((state == ST_START) && (sum == '0)) begin
      out_row  <= col_row_rd;
      out_wgt  <= '0;
      out_last <= emit_last;
    end else if ((state == ST_DIV) && div_rsp.done) begin
      out_row  <= col_row_rd;
      out_wgt  <= div_rsp.quot;
      out_last <= emit_last;
    end
  end

  assign m_axis_tdata = {(OUT_DATA_W - OUT_W - ROW_W)'(0), out_wgt, out_row};
  assign m_axis_tlast = out_last;

endmodule
